// File: sv/assert_macros.svh
// Assertion macros used by the checker file ics_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, masked while reset is high.
`define ICS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every clock, including during reset.
`define ICS_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ics_pkg.sv
// Types and constants for the internet checksum stream unit.
// No dependencies; used by ics_accum and the top level.
`default_nettype none

package ics_pkg;

   localparam int COUNT_WIDTH = 16;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_UDP   = 2'd1;
   localparam logic [1:0] KIND_TCP   = 2'd2;

   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] PROTO_TCP = 8'd6;

   localparam count_type PSEUDO_BIAS = COUNT_WIDTH'(8);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic [1:0] checksum_kind;
   } byte_item_type;

endpackage

`default_nettype wire

// File: sv/ics_accum.sv
// Per-region checksum state and the combinational datapath for one byte.
// Depends on ics_pkg.
`default_nettype none

module ics_accum (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  ics_pkg::byte_item_type  item,
   output logic [15:0]             checksum
);
   import ics_pkg::*;

   logic [15:0] acc_ff, acc_in;
   logic [7:0]  hold_ff, hold_in;
   logic        odd_ff, odd_in;
   count_type   count_ff, count_in;
   logic [1:0]  kind_ff, kind_in;
   logic        in_pkt_ff, in_pkt_in;

   logic        first;
   logic [15:0] acc_base;
   logic        odd_cur;
   count_type   cnt_next;
   logic [1:0]  kind_eff;
   logic [15:0] word;
   logic        pseudo_on;
   logic [7:0]  proto;
   count_type   term;
   logic [17:0] sum_all;
   logic [16:0] fold_a;
   logic [16:0] sum_pair;
   logic [15:0] pair_fold;

   always_comb begin
      first    = !in_pkt_ff;
      acc_base = first ? 16'h0000 : acc_ff;
      odd_cur  = first ? 1'b0 : odd_ff;
      cnt_next = (first ? '0 : count_ff) + COUNT_WIDTH'(1);
      kind_eff = first ? item.checksum_kind : kind_ff;

      // a trailing odd byte sits in the high half, low half zero
      word = odd_cur ? {hold_ff, item.data_byte} : {item.data_byte, 8'h00};

      pseudo_on = (kind_eff == KIND_UDP) || (kind_eff == KIND_TCP);
      proto     = (kind_eff == KIND_UDP) ? PROTO_UDP : PROTO_TCP;
      term      = cnt_next - PSEUDO_BIAS;

      // end-around carry over all terms at once; two folds bring it to 16 bits
      sum_all = {2'b00, acc_base} + {2'b00, word}
              + (pseudo_on ? {10'd0, proto} : 18'd0)
              + (pseudo_on ? {2'b00, 16'(term)} : 18'd0);
      fold_a   = {1'b0, sum_all[15:0]} + {15'd0, sum_all[17:16]};
      checksum = ~(fold_a[15:0] + {15'd0, fold_a[16]});

      sum_pair  = {1'b0, acc_base} + {1'b0, word};
      pair_fold = sum_pair[15:0] + {15'd0, sum_pair[16]};

      acc_in    = acc_ff;
      hold_in   = hold_ff;
      odd_in    = odd_ff;
      count_in  = count_ff;
      kind_in   = kind_ff;
      in_pkt_in = in_pkt_ff;

      if (step) begin
         if (item.last) begin
            acc_in    = 16'h0000;
            hold_in   = 8'h00;
            odd_in    = 1'b0;
            count_in  = '0;
            in_pkt_in = 1'b0;
            kind_in   = kind_eff;
         end else begin
            in_pkt_in = 1'b1;
            count_in  = cnt_next;
            kind_in   = kind_eff;
            if (odd_cur) begin
               acc_in = pair_fold;
               odd_in = 1'b0;
            end else begin
               acc_in  = acc_base;
               hold_in = item.data_byte;
               odd_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 16'h0000;
         hold_ff   <= 8'h00;
         odd_ff    <= 1'b0;
         count_ff  <= '0;
         kind_ff   <= KIND_PLAIN;
         in_pkt_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         hold_ff   <= hold_in;
         odd_ff    <= odd_in;
         count_ff  <= count_in;
         kind_ff   <= kind_in;
         in_pkt_ff <= in_pkt_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/internet_checksum_stream_unit.sv
// A last byte enters the input register; once it advances, its checksum is
// registered in the result register and rsp_valid rises. Throughput: one byte
// per cycle unless a last byte is held behind a checksum waiting on rsp_ready;
// the input and result registers let a new byte enter while a checksum waits.
// Reset (synchronous, active high) empties both registers and starts a new
// region; req_ready is low while reset is high.
`default_nettype none

module internet_checksum_stream_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last,
   input  wire  [1:0]  req_checksum_kind,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_checksum
);
   import ics_pkg::*;

   logic          in_valid_ff, in_valid_in;
   byte_item_type in_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_sum_ff;
   logic          advance;
   logic          accept;
   logic [15:0]   core_sum;

   // a non-last item never needs the result register
   always_comb begin
      advance   = in_valid_ff && (!in_item_ff.last || !rsp_valid_ff || rsp_ready);
      req_ready = !reset && (!in_valid_ff || advance);
      accept    = req_valid && req_ready;

      in_valid_in  = accept || (in_valid_ff && !advance);
      rsp_valid_in = (advance && in_item_ff.last) || (rsp_valid_ff && !rsp_ready);
   end

   ics_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_item_ff),
      .checksum (core_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.data_byte     <= req_data_byte;
         in_item_ff.last          <= req_last;
         in_item_ff.checksum_kind <= req_checksum_kind;
      end
      if (advance && in_item_ff.last) begin
         rsp_sum_ff <= core_sum;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_sum_ff;

endmodule

`default_nettype wire

// File: sv/ics_checker.sv
// Port-level checks for internet_checksum_stream_unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ics_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_last,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [15:0] rsp_checksum
);

   // a waiting checksum holds its value
   `ICS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum), "checksum changed while stalled")

   // reset leaves no checksum pending
   `ICS_ASSERT(a_rsp_reset, clock, $past(reset) |-> !rsp_valid, "rsp_valid after reset")

   // a fresh checksum comes from a last item taken into the input register and passed to the result register
   `ICS_ASSERT_RST(a_rsp_cause, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2), "checksum without a last item")

   // no item is taken while reset is high
   `ICS_ASSERT(a_no_accept_reset, clock, reset |-> !req_ready, "req_ready during reset")

endmodule

bind internet_checksum_stream_unit ics_checker u_ics_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_last     (req_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_checksum (rsp_checksum)
);

`default_nettype wire
